@@ hdl/ftppasv_pkg.sv @@
`default_nettype none

package ftppasv_pkg;

  localparam int unsigned AddrTokens = 4;
  localparam int unsigned AllTokens  = 6;
  localparam int unsigned CountW     = 3;

  localparam logic [7:0] ChOpenParen = 8'h28;
  localparam logic [7:0] ChComma     = 8'h2C;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChPlus      = 8'h2B;
  localparam logic [7:0] ChMinus     = 8'h2D;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChNine      = 8'h39;
  localparam logic [7:0] ChNul       = 8'h00;

  typedef enum logic [1:0] {
    PH_BETWEEN = 2'd0,
    PH_SPACE   = 2'd1,
    PH_DIGITS  = 2'd2,
    PH_TAIL    = 2'd3
  } phase_t;

  typedef struct packed {
    logic [3:0][7:0] ip;
    logic [15:0]     port;
    logic            status;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/ftp_pasv_reply_parser_top.sv @@
// Channel   Signals                                              Direction
// text      text_valid, text_ready, text_byte, is_last           in
// result    result_valid, result_ready, ip_byte0..3, data_port,  out
//           parse_status
//
// One input item is taken per cycle while text_ready is high; a reply's result
// is registered as its final byte is accepted. The per-byte work is a single
// pass of the token logic into the parser state, and results sit in an output
// register backed by one skid entry; text_ready drops only when both are full.
// Reset (rst, synchronous) clears the parser state and empties both result slots.

`default_nettype none

module ftp_pasv_reply_parser_top
  import ftppasv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        text_valid,
  output logic             text_ready,
  input  wire logic [7:0]  text_byte,
  input  wire logic        is_last,
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic [7:0]       ip_byte0,
  output logic [7:0]       ip_byte1,
  output logic [7:0]       ip_byte2,
  output logic [7:0]       ip_byte3,
  output logic [15:0]      data_port,
  output logic             parse_status
);

  // Parser state
  logic              paren_seen, paren_seen_next;
  logic              prefix_started, prefix_started_next;
  logic              text_ended, text_ended_next;
  logic [CountW-1:0] token_count, token_count_next;
  phase_t            token_phase, token_phase_next;
  logic              negative_sign, negative_sign_next;
  logic [15:0]       digit_accumulator, digit_accumulator_next;
  logic [3:0][7:0]   address_bytes, address_bytes_next;
  logic [15:0]       port_value, port_value_next;

  // Result slots
  logic    skid_valid;
  result_t out_data, skid_data, res;

  logic        in_fire, push, pop;
  logic        is_ws, is_delim, is_digit, feed_fin, fin, ok;
  logic        tokens_done;
  logic [15:0] acc_times10, fin_value;
  phase_t      ph_f;
  logic        neg_f;
  logic [15:0] acc_f;
  logic [CountW-1:0] count_f;
  logic [3:0][7:0]   addr_f;
  logic [15:0]       port_f;

  assign text_ready = !skid_valid;
  assign in_fire    = text_valid && text_ready;
  assign push       = in_fire && is_last;
  assign pop        = result_valid && result_ready;

  assign is_ws    = (text_byte == ChSpace) || (text_byte >= ChTab && text_byte <= ChCr);
  assign is_digit = (text_byte >= ChZero) && (text_byte <= ChNine);
  assign tokens_done = (token_count >= CountW'(AllTokens));
  // CR and LF end the first token and the two port tokens only.
  assign is_delim = (text_byte == ChComma) ||
                    (((token_count == '0) || (token_count >= CountW'(AddrTokens))) &&
                     ((text_byte == ChCr) || (text_byte == ChLf)));
  assign acc_times10 = {digit_accumulator[12:0], 3'b000} + {digit_accumulator[14:0], 1'b0};

  always_comb begin
    paren_seen_next     = paren_seen;
    prefix_started_next = prefix_started;
    text_ended_next     = text_ended;
    ph_f                = token_phase;
    neg_f               = negative_sign;
    acc_f               = digit_accumulator;
    feed_fin            = 1'b0;

    if (text_ended) begin
      // Text already over; wait for the final byte.
    end else if (text_byte == ChNul) begin
      text_ended_next = 1'b1;
    end else if (!paren_seen) begin
      if (text_byte == ChOpenParen) begin
        if (prefix_started) begin
          paren_seen_next = 1'b1;
        end
      end else begin
        prefix_started_next = 1'b1;
      end
    end else if (tokens_done) begin
      // Trailing text after the sixth token is ignored.
    end else if (is_delim) begin
      feed_fin = (token_phase != PH_BETWEEN);
    end else begin
      unique case (token_phase)
        PH_BETWEEN, PH_SPACE: begin
          if (is_ws) begin
            ph_f = PH_SPACE;
          end else if (text_byte == ChPlus || text_byte == ChMinus) begin
            neg_f = (text_byte == ChMinus);
            ph_f  = PH_DIGITS;
          end else if (is_digit) begin
            acc_f = acc_times10 + {12'd0, text_byte[3:0]};
            ph_f  = PH_DIGITS;
          end else begin
            ph_f = PH_TAIL;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            acc_f = acc_times10 + {12'd0, text_byte[3:0]};
          end else begin
            ph_f = PH_TAIL;
          end
        end
        PH_TAIL: begin
        end
        default: begin
        end
      endcase
    end
  end

  // A token ends on a delimiter, or at the final byte if one is still open.
  assign fin = feed_fin ||
               (is_last && paren_seen_next && !tokens_done && (ph_f != PH_BETWEEN));
  assign fin_value = neg_f ? (16'd0 - acc_f) : acc_f;

  always_comb begin
    addr_f  = address_bytes;
    port_f  = port_value;
    count_f = token_count;
    if (fin) begin
      if (token_count < CountW'(AddrTokens)) begin
        addr_f[token_count[1:0]] = fin_value[7:0];
      end else begin
        port_f = {port_value[7:0], 8'd0} + fin_value;
      end
      count_f = token_count + CountW'(1);
    end
  end

  assign ok = (count_f >= CountW'(AllTokens));

  always_comb begin
    res.ip     = addr_f;
    res.port   = ok ? port_f : 16'd0;
    res.status = !ok;
  end

  always_comb begin
    token_count_next       = count_f;
    token_phase_next       = fin ? PH_BETWEEN : ph_f;
    negative_sign_next     = fin ? 1'b0 : neg_f;
    digit_accumulator_next = fin ? 16'd0 : acc_f;
    address_bytes_next     = addr_f;
    port_value_next        = port_f;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      paren_seen        <= 1'b0;
      prefix_started    <= 1'b0;
      text_ended        <= 1'b0;
      token_count       <= '0;
      token_phase       <= PH_BETWEEN;
      negative_sign     <= 1'b0;
      digit_accumulator <= '0;
      address_bytes     <= '0;
      port_value        <= '0;
    end else if (in_fire) begin
      paren_seen        <= paren_seen_next;
      prefix_started    <= prefix_started_next;
      text_ended        <= text_ended_next;
      token_count       <= token_count_next;
      token_phase       <= token_phase_next;
      negative_sign     <= negative_sign_next;
      digit_accumulator <= digit_accumulator_next;
      address_bytes     <= address_bytes_next;
      port_value        <= port_value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= push;
      end else begin
        result_valid <= push;
      end
    end else if (!result_valid) begin
      result_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (push) begin
          skid_data <= res;
        end
      end else if (push) begin
        out_data <= res;
      end
    end else if (!result_valid) begin
      if (push) begin
        out_data <= res;
      end
    end else if (push) begin
      skid_data <= res;
    end
  end

  assign ip_byte0     = out_data.ip[0];
  assign ip_byte1     = out_data.ip[1];
  assign ip_byte2     = out_data.ip[2];
  assign ip_byte3     = out_data.ip[3];
  assign data_port    = out_data.port;
  assign parse_status = out_data.status;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry holds a result while the output register is empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    token_count <= CountW'(AllTokens))
    else $error("token count ran past six");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    push |=> (token_count == '0) && !paren_seen && (token_phase == PH_BETWEEN))
    else $error("parser state not cleared after the final byte");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    push |=> result_valid)
    else $error("final byte accepted but no result presented");
`endif

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import ftppasv_pkg::*;

  typedef struct {
    logic [7:0] b;
    bit         last;
    bit         drain;
    bit         typed;
    result_t    want;
  } text_item_t;

  typedef struct {
    string      txt;
    logic [7:0] tail;
    bit         typed;
    result_t    want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        text_valid = 1'b0;
  logic        text_ready;
  logic [7:0]  text_byte = 8'h00;
  logic        is_last = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [7:0]  ip_byte0;
  logic [7:0]  ip_byte1;
  logic [7:0]  ip_byte2;
  logic [7:0]  ip_byte3;
  logic [15:0] data_port;
  logic        parse_status;

  ftp_pasv_reply_parser_top dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_ready   (text_ready),
    .text_byte    (text_byte),
    .is_last      (is_last),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .ip_byte0     (ip_byte0),
    .ip_byte1     (ip_byte1),
    .ip_byte2     (ip_byte2),
    .ip_byte3     (ip_byte3),
    .data_port    (data_port),
    .parse_status (parse_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Parser state mirrored by the predictor.
  bit              pv_paren;
  bit              pv_prefix;
  bit              pv_ended;
  int unsigned     pv_count;
  phase_t          pv_phase;
  bit              pv_neg;
  logic [15:0]     pv_acc;
  logic [3:0][7:0] pv_addr;
  logic [15:0]     pv_port;

  text_item_t  text_items[$];
  result_t     reply_due[$];
  logic [7:0]  reply_bytes[$];
  text_item_t  cur_item;
  dir_row_t    dir_rows[5];
  int unsigned bytes_taken = 0;
  int unsigned mismatches = 0;
  logic        quiet;

  // Neither side idles through this stretch of the run.
  assign quiet = (bytes_taken >= 700) && (bytes_taken < 1000);

  function automatic result_t mk_result(logic [7:0] a0, logic [7:0] a1, logic [7:0] a2,
                                        logic [7:0] a3, logic [15:0] port, logic status);
    result_t r;
    r.ip = {a3, a2, a1, a0};
    r.port = port;
    r.status = status;
    return r;
  endfunction

  function automatic void pasv_clear();
    pv_paren = 1'b0;
    pv_prefix = 1'b0;
    pv_ended = 1'b0;
    pv_count = 0;
    pv_phase = PH_BETWEEN;
    pv_neg = 1'b0;
    pv_acc = 16'h0000;
    pv_addr = '0;
    pv_port = 16'h0000;
  endfunction

  function automatic void pasv_close_token();
    logic [15:0] v;
    v = pv_neg ? 16'd0 - pv_acc : pv_acc;
    if (pv_count < AddrTokens) pv_addr[pv_count] = v[7:0];
    else pv_port = (pv_port << 8) + v;
    pv_count++;
    pv_phase = PH_BETWEEN;
    pv_neg = 1'b0;
    pv_acc = 16'h0000;
  endfunction

  function automatic void pasv_feed(logic [7:0] c);
    bit delim;
    if (pv_ended) return;
    if (c == ChNul) begin
      pv_ended = 1'b1;
      return;
    end
    // Parens at the very start are skipped; only one after other text opens the list.
    if (!pv_paren) begin
      if (c != ChOpenParen) pv_prefix = 1'b1;
      else if (pv_prefix) pv_paren = 1'b1;
      return;
    end
    if (pv_count >= AllTokens) return;
    delim = (c == ChComma) ||
            ((pv_count == 0 || pv_count >= AddrTokens) && (c == ChCr || c == ChLf));
    if (delim) begin
      if (pv_phase != PH_BETWEEN) pasv_close_token();
      return;
    end
    if (pv_phase == PH_BETWEEN) pv_phase = PH_SPACE;
    if (pv_phase == PH_SPACE) begin
      if (c == ChSpace || (c >= ChTab && c <= ChCr)) return;
      if (c == ChPlus || c == ChMinus) begin
        pv_neg = (c == ChMinus);
        pv_phase = PH_DIGITS;
        return;
      end
      pv_phase = PH_DIGITS;
    end
    if (pv_phase == PH_DIGITS) begin
      if (c >= ChZero && c <= ChNine) pv_acc = pv_acc * 16'd10 + 16'(c - ChZero);
      else pv_phase = PH_TAIL;
    end
  endfunction

  function automatic bit pasv_step(logic [7:0] c, bit last, output result_t r);
    bit ok;
    r = '0;
    pasv_feed(c);
    if (!last) return 1'b0;
    if (pv_paren && pv_count < AllTokens && pv_phase != PH_BETWEEN) pasv_close_token();
    ok = (pv_count >= AllTokens);
    r.ip = pv_addr;
    r.port = ok ? pv_port : 16'h0000;
    r.status = !ok;
    pasv_clear();
    return 1'b1;
  endfunction

  task automatic note_mismatch(string what);
    if (mismatches < 40) $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) reply_bytes.push_back(s[i]);
  endtask

  task automatic append_token();
    int unsigned v;
    bit          has_digits;
    case ($urandom_range(9))
      0: reply_bytes.push_back(ChSpace);
      1: reply_bytes.push_back(8'($urandom_range(9, 13)));
      default: ;
    endcase
    case ($urandom_range(19))
      0: reply_bytes.push_back(ChMinus);
      1: reply_bytes.push_back(ChPlus);
      default: ;
    endcase
    has_digits = 1'b1;
    case ($urandom_range(11))
      0: v = $urandom_range(9999999);
      1: v = $urandom_range(65535);
      2: v = $urandom_range(1) * 255;
      3: has_digits = 1'b0;
      default: v = $urandom_range(255);
    endcase
    if (has_digits) push_str($sformatf("%0d", v));
    case ($urandom_range(11))
      0: push_str("x7");
      1: reply_bytes.push_back(ChSpace);
      default: ;
    endcase
  endtask

  // One reply: mostly well-formed with random content, some broken, some plain noise.
  task automatic build_reply(bit drain);
    int unsigned n;
    int unsigned pos;
    reply_bytes.delete();
    if ($urandom_range(3) == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) reply_bytes.push_back(8'($urandom_range(255)));
    end else begin
      case ($urandom_range(4))
        0: push_str("227 Entering Passive Mode (");
        1: push_str("227 (");
        2: push_str("((227 (");
        3: begin
          n = $urandom_range(3);
          repeat (n) reply_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
          reply_bytes.push_back(ChOpenParen);
        end
        default: push_str("(x(");
      endcase
      for (int t = 0; t < AllTokens; t++) begin
        append_token();
        if (t < AllTokens - 1) begin
          case ($urandom_range(15))
            0: push_str(",,");
            1: reply_bytes.push_back((t == 0 || t == AddrTokens) ? ChCr : ChComma);
            2: reply_bytes.push_back((t == 0 || t == AddrTokens) ? ChLf : ChComma);
            default: reply_bytes.push_back(ChComma);
          endcase
        end
      end
      if ($urandom_range(5) != 0) push_str(")");
      if ($urandom_range(2) != 0) push_str("\r\n");
      if ($urandom_range(9) == 0) push_str(",1,2");
      case ($urandom_range(11))
        0: reply_bytes = reply_bytes[0:$urandom_range(reply_bytes.size() - 1)];
        1: begin
          pos = $urandom_range(reply_bytes.size() - 1);
          reply_bytes[pos] = ChNul;
        end
        2: if (reply_bytes.size() > 1) reply_bytes.delete($urandom_range(reply_bytes.size() - 1));
        default: ;
      endcase
    end
    foreach (reply_bytes[i])
      text_items.push_back('{reply_bytes[i], i == reply_bytes.size() - 1, drain && i == 0,
                             1'b0, result_t'('0)});
  endtask

  // Sender side.
  always @(posedge clk) begin : drive_text
    result_t r;
    bit      go;
    if (rst) begin
      text_valid <= 1'b0;
      text_byte <= 8'h00;
      is_last <= 1'b0;
    end else begin
      if (text_valid && text_ready) begin
        bytes_taken++;
        if (pasv_step(cur_item.b, cur_item.last, r))
          reply_due.push_back(cur_item.typed ? cur_item.want : r);
      end
      if (!text_valid || text_ready) begin
        go = (text_items.size() != 0) && (quiet || $urandom_range(99) >= 11);
        if (go && text_items[0].drain && reply_due.size() != 0) go = 1'b0;
        if (go) begin
          cur_item = text_items.pop_front();
          text_byte <= cur_item.b;
          is_last <= cur_item.last;
        end
        text_valid <= go;
      end
    end
  end

  // Receiver side.
  always @(posedge clk) begin : watch_results
    result_t         w;
    logic [3:0][7:0] got_ip;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (reply_due.size() == 0) begin
          note_mismatch("result with no reply pending");
        end else begin
          w = reply_due.pop_front();
          got_ip = {ip_byte3, ip_byte2, ip_byte1, ip_byte0};
          for (int i = 0; i < AddrTokens; i++)
            if (got_ip[i] !== w.ip[i])
              note_mismatch($sformatf("ip_byte%0d %h, expected %h", i, got_ip[i], w.ip[i]));
          if (data_port !== w.port)
            note_mismatch($sformatf("data_port %h, expected %h", data_port, w.port));
          if (parse_status !== w.status)
            note_mismatch($sformatf("parse_status %b, expected %b", parse_status, w.status));
        end
      end
      result_ready <= quiet || ($urandom_range(99) >= 11);
    end
  end

  initial begin
    int unsigned replies;
    pasv_clear();
    dir_rows[0] = '{"", 8'hFF, 1'b1, mk_result(0, 0, 0, 0, 0, 1)};
    dir_rows[1] = '{"", ChNul, 1'b1, mk_result(0, 0, 0, 0, 0, 1)};
    dir_rows[2] = '{"a(9,,8,7,6,1,", ChZero + 8'd2, 1'b1, mk_result(9, 8, 7, 6, 258, 0)};
    // Only parens at the start: the list never opens.
    dir_rows[3] = '{"((", ChOpenParen, 1'b1, mk_result(0, 0, 0, 0, 0, 1)};
    // A line feed does not end the second token; the final byte closes it.
    dir_rows[4] = '{"q(-1,", ChLf, 1'b0, result_t'('0)};
    foreach (dir_rows[r]) begin
      for (int i = 0; i < dir_rows[r].txt.len(); i++)
        text_items.push_back('{dir_rows[r].txt[i], 1'b0, 1'b0, 1'b0, result_t'('0)});
      text_items.push_back('{dir_rows[r].tail, 1'b1, 1'b0, dir_rows[r].typed,
                             dir_rows[r].want});
    end
    replies = 0;
    while (text_items.size() < 1850) begin
      build_reply(replies == 0 || $urandom_range(14) == 0);
      replies++;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (text_items.size() != 0 || text_valid) @(posedge clk);
    while (reply_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
hdl/ftppasv_pkg.sv
hdl/ftp_pasv_reply_parser_top.sv
test/tb_top.sv
